### rtl/core/bounded_deque_with_reverse_core_macros.svh
// Assertion helpers shared by the deque core. Each macro checks on the rising
// edge of clk_i and is disabled while rst_ni is low.
`ifndef BOUNDED_DEQUE_WITH_REVERSE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_WITH_REVERSE_CORE_MACROS_SVH

`ifndef SYNTH

`define BDQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("deque core assertion failed");

`define BDQ_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("deque core forbidden condition seen");

`else

`define BDQ_ASSERT(lbl, prop)

`define BDQ_ASSERT_NEVER(lbl, expr)

`endif

`endif

### rtl/core/bdq_pkg.sv
package bdq_pkg;

  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int FILL_W       = 6;
  localparam int DEF_CAPACITY = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_DUMP       = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_POP_FRONT  = 3'd4,
    CMD_REVERSE    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  typedef struct packed {
    logic apply;
    logic dump_start;
    logic dump_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic idx_last;
  } dp_status_t;

endpackage

### rtl/core/bdq_in_if.sv
interface bdq_in_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          command;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output command, output item_value, input ready);
  modport sink (input valid, input command, input item_value, output ready);
endinterface

### rtl/core/bdq_out_if.sv
interface bdq_out_if import bdq_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0]       status;
  logic [FILL_W-1:0]         fill_level;
  logic                      last;

  modport source (
    output valid, output out_value, output status, output fill_level, output last,
    input ready
  );
  modport sink (
    input valid, input out_value, input status, input fill_level, input last,
    output ready
  );
endinterface

### rtl/core/bdq_ram.sv
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/bdq_ctrl.sv
`include "bounded_deque_with_reverse_core_macros.svh"

module bdq_ctrl import bdq_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_command_i,
  input  logic             out_ready_i,
  input  dp_status_t       status_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output ctrl_cmd_t        cmd_o
);

  state_e    state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;
  ctrl_cmd_t cmd;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd        = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (in_command_i == CMD_DUMP && !status_i.occ_zero) begin
            cmd.dump_start = 1'b1;
            state_d        = S_DUMP;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      S_DUMP: begin
        if (out_free) begin
          cmd.dump_emit = 1'b1;
          if (status_i.idx_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cmd.apply || cmd.dump_emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  `BDQ_ASSERT(a_load_source, $rose(out_valid_q) |-> $past(cmd.apply || cmd.dump_emit))
  `BDQ_ASSERT_NEVER(a_single_action, cmd.apply && (cmd.dump_emit || cmd.dump_start))
  `BDQ_ASSERT(a_dump_ends_idle, (cmd.dump_emit && status_i.idx_last) |=> state_q == S_IDLE)

endmodule

### rtl/core/bdq_dp.sv
`include "bounded_deque_with_reverse_core_macros.svh"

module bdq_dp import bdq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ctrl_cmd_t                  cmd_i,
  input  logic [CMD_W-1:0]           command_i,
  input  logic signed [VALUE_W-1:0]  item_value_i,
  output dp_status_t                 status_o,
  output logic signed [VALUE_W-1:0]  out_value_o,
  output logic [STATUS_W-1:0]        out_status_o,
  output logic [FILL_W-1:0]          fill_level_o,
  output logic                       last_o
);

  localparam int PW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int SW = OW + 1;

  logic [PW-1:0] front_q, front_d;
  logic [OW-1:0] occ_q, occ_d;
  logic          rev_q, rev_d;
  logic [OW-1:0] idx_q, idx_d;

  logic signed [VALUE_W-1:0] out_value_q;
  logic [STATUS_W-1:0]       out_status_q;
  logic [FILL_W-1:0]         fill_q;
  logic                      last_q;

  logic                full, empty, idx_last;
  logic [PW-1:0]       back_slot, next_slot, tail_slot, pre_slot, rd_slot;
  logic                we;
  logic [PW-1:0]       waddr;
  logic [VALUE_W-1:0]  rdata;
  status_e             sts;

  // Physical slot of a logical offset; an offset equal to the capacity wraps to zero.
  function automatic logic [PW-1:0] slot_at(logic [OW-1:0] off, logic [PW-1:0] front,
                                            logic rev);
    logic [SW-1:0] o;
    logic [SW-1:0] f;
    logic [SW-1:0] cap;
    logic [SW-1:0] r;
    cap = SW'(CAPACITY);
    o   = (SW'(off) == cap) ? '0 : SW'(off);
    f   = SW'(front);
    if (rev) begin
      r = (f >= o) ? (f - o) : (f + cap - o);
    end else begin
      r = f + o;
      if (r >= cap) begin
        r = r - cap;
      end
    end
    return r[PW-1:0];
  endfunction

  assign full      = (occ_q == OW'(CAPACITY));
  assign empty     = (occ_q == '0);
  assign idx_last  = (OW'(idx_q + OW'(1)) == occ_q);
  assign back_slot = slot_at(occ_q, front_q, rev_q);
  assign next_slot = slot_at(OW'(1), front_q, rev_q);
  assign tail_slot = slot_at(OW'(occ_q - OW'(1)), front_q, rev_q);
  assign rd_slot   = slot_at(idx_d, front_q, rev_q);

  always_comb begin
    if (rev_q) begin
      pre_slot = (front_q == PW'(CAPACITY - 1)) ? '0 : PW'(front_q + PW'(1));
    end else begin
      pre_slot = (front_q == '0) ? PW'(CAPACITY - 1) : PW'(front_q - PW'(1));
    end
  end

  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    rev_d   = rev_q;
    we      = 1'b0;
    waddr   = back_slot;
    sts     = STS_OK;
    if (cmd_i.apply) begin
      case (command_i)
        CMD_DUMP: begin
          sts = STS_EMPTY;
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            sts = STS_FULL;
          end else begin
            we    = 1'b1;
            occ_d = OW'(occ_q + OW'(1));
          end
        end
        CMD_PUSH_FRONT: begin
          if (full) begin
            sts = STS_FULL;
          end else begin
            we      = 1'b1;
            waddr   = pre_slot;
            front_d = pre_slot;
            occ_d   = OW'(occ_q + OW'(1));
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            sts = STS_EMPTY;
          end else begin
            occ_d = OW'(occ_q - OW'(1));
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            sts = STS_EMPTY;
          end else begin
            front_d = next_slot;
            occ_d   = OW'(occ_q - OW'(1));
          end
        end
        CMD_REVERSE: begin
          if (!empty) begin
            front_d = tail_slot;
          end
          rev_d = !rev_q;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cmd_i.dump_start) begin
      idx_d = '0;
    end else if (cmd_i.dump_emit) begin
      idx_d = OW'(idx_q + OW'(1));
    end else begin
      idx_d = idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
      rev_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      occ_q   <= occ_d;
      rev_q   <= rev_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      out_value_q  <= '0;
      out_status_q <= sts;
      fill_q       <= FILL_W'(occ_d);
      last_q       <= 1'b1;
    end else if (cmd_i.dump_emit) begin
      out_value_q  <= rdata;
      out_status_q <= STS_OK;
      fill_q       <= FILL_W'(occ_q);
      last_q       <= idx_last;
    end
  end

  bdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (item_value_i),
    .raddr_i (rd_slot),
    .rdata_o (rdata)
  );

  assign status_o.occ_zero = empty;
  assign status_o.idx_last = idx_last;
  assign out_value_o       = out_value_q;
  assign out_status_o      = out_status_q;
  assign fill_level_o      = fill_q;
  assign last_o            = last_q;

  `BDQ_ASSERT_NEVER(a_occ_bound, occ_q > OW'(CAPACITY))
  `BDQ_ASSERT(a_idx_in_range, cmd_i.dump_emit |-> idx_q < occ_q)
  `BDQ_ASSERT(a_dump_keeps_state, cmd_i.dump_emit |=> $stable(occ_q) && $stable(front_q))

endmodule

### rtl/core/bounded_deque_with_reverse_core.sv
// Bounded double-ended queue of signed 32-bit values with constant-time
// reversal. Each input item carries one command: dump, push back, push front,
// pop back, pop front or reverse. Every command except a dump of a non-empty
// queue finishes in the cycle it is accepted and gives one status item, so such
// commands can be taken one per cycle while the output side keeps up. A dump of
// n elements gives n items, front to back, with last set on the final one; the
// read of the first element is issued in the accepting cycle, and new input is
// then held off while the elements are emitted, one per cycle, stretched by any
// output stall.
// A push into a full queue is dropped with a full status, and a pop or a dump on
// an empty queue reports an empty status and leaves the queue unchanged.
// Element store contents are undefined after reset until written; no clearing
// pass is needed since only occupied slots ever reach the output.
module bounded_deque_with_reverse_core import bdq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bdq_in_if.sink           cmd_i,
  bdq_out_if.source        rsp_o
);

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  bdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .out_ready_i  (rsp_o.ready),
    .status_i     (dp_status),
    .in_ready_o   (cmd_i.ready),
    .out_valid_o  (rsp_o.valid),
    .cmd_o        (ctrl_cmd)
  );

  bdq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .command_i    (cmd_i.command),
    .item_value_i (cmd_i.item_value),
    .status_o     (dp_status),
    .out_value_o  (rsp_o.out_value),
    .out_status_o (rsp_o.status),
    .fill_level_o (rsp_o.fill_level),
    .last_o       (rsp_o.last)
  );

endmodule

### dv/testbench.sv
module testbench;
  import bdq_pkg::*;

  localparam int CAP = DEF_CAPACITY;
  localparam int PTR_W = $clog2(CAP);
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4 * CAP;
  localparam int NUM_DIR = 25;

  typedef enum int {
    MIX_ANY,
    MIX_FILL,
    MIX_DRAIN
  } mix_e;

  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [VALUE_W-1:0]  value;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill;
  } dir_row_t;

  typedef struct packed {
    logic typed;
    rsp_t rsp;
  } listed_t;

  localparam listed_t NO_LISTED = '0;

  // Rows with typed set carry the status item expected for them; the others
  // are checked against the deque predictor.
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{CMD_DUMP,       32'h0000_0000, 1'b1, STS_EMPTY, 6'd0},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STS_EMPTY, 6'd0},
    '{CMD_POP_FRONT,  32'hFFFF_FFFF, 1'b1, STS_EMPTY, 6'd0},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, STS_OK,    6'd0},
    '{CMD_SPARE_6,    32'h1234_5678, 1'b1, STS_OK,    6'd0},
    '{CMD_SPARE_7,    32'hFFFF_FFFF, 1'b1, STS_OK,    6'd0},
    '{CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, STS_OK,    6'd1},
    '{CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, STS_OK,    6'd2},
    '{CMD_PUSH_BACK,  32'h0000_0000, 1'b1, STS_OK,    6'd3},
    '{CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, STS_OK,    6'd4},
    '{CMD_DUMP,       32'h0000_0000, 1'b0, STS_OK,    6'd0},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, STS_OK,    6'd4},
    '{CMD_DUMP,       32'hFFFF_FFFF, 1'b0, STS_OK,    6'd0},
    '{CMD_PUSH_BACK,  32'h5555_5555, 1'b1, STS_OK,    6'd5},
    '{CMD_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, STS_OK,    6'd6},
    '{CMD_DUMP,       32'h0000_0000, 1'b0, STS_OK,    6'd0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, STS_OK,    6'd5},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STS_OK,    6'd4},
    '{CMD_REVERSE,    32'h0000_0000, 1'b1, STS_OK,    6'd4},
    '{CMD_DUMP,       32'h0000_0000, 1'b0, STS_OK,    6'd0},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, STS_OK,    6'd3},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STS_OK,    6'd2},
    '{CMD_POP_FRONT,  32'h0000_0000, 1'b1, STS_OK,    6'd1},
    '{CMD_POP_BACK,   32'h0000_0000, 1'b1, STS_OK,    6'd0},
    '{CMD_DUMP,       32'h0000_0000, 1'b1, STS_EMPTY, 6'd0}
  };

  logic clk_i;
  logic rst_ni;

  bdq_in_if  cmd_if ();
  bdq_out_if rsp_if ();

  bounded_deque_with_reverse_core #(
    .CAPACITY(CAP)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  logic [VALUE_W-1:0] dq_slots [CAP];
  logic [PTR_W-1:0]   dq_head    = '0;
  logic [FILL_W-1:0]  dq_count   = '0;
  logic               dq_flipped = 1'b0;

  rsp_t    pending_rsps [$];
  listed_t listed_q [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      src_idle_pct = 20;
  int      sink_idle_pct = 61;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [PTR_W-1:0] dq_slot(input int off);
    int o;
    o = off % CAP;
    if (dq_flipped) return PTR_W'((int'(dq_head) + CAP - o) % CAP);
    return PTR_W'((int'(dq_head) + o) % CAP);
  endfunction

  function automatic void deque_apply(input logic [CMD_W-1:0] cmd,
                                      input logic [VALUE_W-1:0] val, input listed_t hint);
    rsp_t                outs [$];
    logic [STATUS_W-1:0] st;
    st = STS_OK;
    case (cmd)
      CMD_DUMP: begin
        if (dq_count == 0) st = STS_EMPTY;
        for (int i = 0; i < int'(dq_count); i++)
          outs.push_back('{dq_slots[dq_slot(i)], STS_OK, dq_count,
                           1'(i == int'(dq_count) - 1)});
      end
      CMD_PUSH_BACK: begin
        if (dq_count >= CAP) begin
          st = STS_FULL;
        end else begin
          dq_slots[dq_slot(int'(dq_count))] = val;
          dq_count++;
        end
      end
      CMD_PUSH_FRONT: begin
        if (dq_count >= CAP) begin
          st = STS_FULL;
        end else begin
          dq_head = dq_flipped ? PTR_W'((int'(dq_head) + 1) % CAP)
                               : PTR_W'((int'(dq_head) + CAP - 1) % CAP);
          dq_slots[dq_head] = val;
          dq_count++;
        end
      end
      CMD_POP_BACK: begin
        if (dq_count == 0) st = STS_EMPTY;
        else dq_count--;
      end
      CMD_POP_FRONT: begin
        if (dq_count == 0) begin
          st = STS_EMPTY;
        end else begin
          dq_head = dq_slot(1);
          dq_count--;
        end
      end
      CMD_REVERSE: begin
        if (dq_count != 0) dq_head = dq_slot(int'(dq_count) - 1);
        dq_flipped = ~dq_flipped;
      end
      default: ;
    endcase
    if (outs.size() == 0) outs.push_back('{'0, st, dq_count, 1'b1});
    if (hint.typed) pending_rsps.push_back(hint.rsp);
    else foreach (outs[k]) pending_rsps.push_back(outs[k]);
  endfunction

  function automatic void report_bad(input string what, input rsp_t want, input rsp_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected value=%0d status=%0d fill=%0d last=%0b, %s",
               what, $signed(want.value), want.status, want.fill, want.last,
               $sformatf("got value=%0d status=%0d fill=%0d last=%0b",
                         $signed(got.value), got.status, got.fill, got.last));
  endfunction

  always @(posedge clk_i) begin
    rsp_t    got;
    listed_t hint;
    if (rst_ni) begin
      quiet_cycles++;
      if (cmd_if.valid && cmd_if.ready) begin
        quiet_cycles = 0;
        hint = listed_q.pop_front();
        deque_apply(cmd_if.command, cmd_if.item_value, hint);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        quiet_cycles = 0;
        got = '{rsp_if.out_value, rsp_if.status, rsp_if.fill_level, rsp_if.last};
        if (pending_rsps.size() == 0) report_bad("unexpected item", '0, got);
        else if (pending_rsps[0] !== got) report_bad("mismatch", pending_rsps.pop_front(), got);
        else void'(pending_rsps.pop_front());
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                          input listed_t hint);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    listed_q.push_back(hint);
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.item_value <= val;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
  endtask

  task automatic run_burst(input mix_e mix, input int n);
    logic [CMD_W-1:0] cmd;
    int               r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      case (mix)
        MIX_FILL: begin
          cmd = (r < 42) ? CMD_PUSH_BACK : (r < 84) ? CMD_PUSH_FRONT :
                (r < 92) ? CMD_DUMP : CMD_REVERSE;
        end
        MIX_DRAIN: begin
          cmd = (r < 42) ? CMD_POP_BACK : (r < 84) ? CMD_POP_FRONT :
                (r < 92) ? CMD_DUMP : CMD_REVERSE;
        end
        default: cmd = CMD_W'($urandom_range(7));
      endcase
      send_cmd(cmd, $urandom, NO_LISTED);
    end
  endtask

  task automatic wait_for_rsps();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    listed_t hint;
    rst_ni            <= 1'b0;
    cmd_if.valid      <= 1'b0;
    cmd_if.command    <= '0;
    cmd_if.item_value <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int d = 0; d < NUM_DIR; d++) begin
      hint.typed = DIR_ROWS[d].typed;
      hint.rsp   = '{'0, DIR_ROWS[d].status, DIR_ROWS[d].fill, 1'b1};
      send_cmd(DIR_ROWS[d].cmd, DIR_ROWS[d].value, hint);
    end
    run_burst(MIX_ANY, 24);
    run_burst(MIX_FILL, 44);
    wait_for_rsps();

    src_idle_pct  = 61;
    sink_idle_pct = 20;
    run_burst(MIX_ANY, 20);
    run_burst(MIX_DRAIN, 44);
    wait_for_rsps();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_burst(MIX_FILL, 44);
    run_burst(MIX_ANY, 16);

    wait_for_rsps();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bdq_pkg.sv
rtl/core/bdq_in_if.sv
rtl/core/bdq_out_if.sv
rtl/core/bdq_ram.sv
rtl/core/bdq_ctrl.sv
rtl/core/bdq_dp.sv
rtl/core/bounded_deque_with_reverse_core.sv
dv/testbench.sv
